// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and cut off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/mot_pkg.sv -----
// ----------------------------------------------------------------------------
// mot_pkg
// Widths, queue word type, state and operation codes of the Otsu finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mot_pkg;
	localparam int COUNT_BITS = 20;
	localparam int N_W        = COUNT_BITS + 1;
	localparam int S_W        = COUNT_BITS + 9;
	localparam int P1_W       = N_W + S_W;
	localparam int SQ_W       = 2 * P1_W;
	localparam int DEN_W      = 2 * N_W;
	localparam int CMP_W      = SQ_W + DEN_W;
	localparam int MA_W       = SQ_W;
	localparam int MB_W       = P1_W;
	localparam int MP_W       = MA_W + MB_W;
	localparam int BIN_W      = 8;
	localparam int BINS       = 1 << BIN_W;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [N_W-1:0] PIX_CAP = {1'b1, {COUNT_BITS{1'b0}}};

	// One queue word: a classified pixel
	typedef struct packed {
		logic [BIN_W-1:0] pixel;
		logic             inc;
		logic             ovf;
		logic             last;
	} item_t;

	// Frame result from back end
	typedef struct packed {
		logic             done;
		logic [BIN_W-1:0] threshold;
		logic             empty_frame;
		logic             overflow;
	} res_t;

	typedef enum logic [3:0] {
		B_INIT, B_RUN, B_RD, B_ACC, B_CHK, B_MGO, B_MWAIT, B_NEXT, B_CLR, B_DONE
	} bstate_t;

	typedef enum logic [2:0] {
		OP_PA, OP_PB, OP_DSQ, OP_DEN, OP_LHS, OP_RHS
	} op_t;
endpackage

// ----- rtl/core/mot_fifo.sv -----
// ----------------------------------------------------------------------------
// mot_fifo
// Short word queue between the classifying front end and the histogram back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mot_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mot_pkg::item_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output mot_pkg::item_t rdata
);
	import mot_pkg::*;

	item_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (!push && pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	// store word
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	`ASSERT_NEVER(a_no_push_full, push && full, "word pushed into full queue")
	`ASSERT_NEVER(a_no_pop_empty, pop && empty, "word popped from empty queue")
endmodule

// ----- rtl/core/mot_front.sv -----
// ----------------------------------------------------------------------------
// mot_front
// Accepts pixels, applies the mask and the count capacity, and queues words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mot_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [mot_pkg::BIN_W-1:0] pixel,
	input  logic                     in_mask,
	input  logic                     last,
	output logic                     busy,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_data,
	input  logic                     frame_done,
	output logic                     push,
	output mot_pkg::item_t           word,
	input  logic                     full
);
	import mot_pkg::*;

	logic           mask_en_q;
	logic           hold_q;
	logic [N_W-1:0] cnt_q;
	logic           counted;

	assign busy      = full || hold_q;
	assign cfg_ready = 1'b1;
	assign push      = start && !busy;
	assign counted   = !mask_en_q || in_mask;

	// classify pixel
	always_comb begin
		word.pixel = pixel;
		word.inc   = counted && (cnt_q < PIX_CAP);
		word.ovf   = counted && (cnt_q >= PIX_CAP);
		word.last  = last;
	end

	// hold register, capacity count and frame hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_en_q <= 1'b0;
			hold_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) mask_en_q <= cfg_data;
			if (push && last) begin
				hold_q <= 1'b1;
				cnt_q  <= '0;
			end else begin
				if (frame_done) hold_q <= 1'b0;
				if (push && word.inc) cnt_q <= cnt_q + 1'b1;
			end
		end
	end
endmodule

// ----- rtl/core/mot_mul.sv -----
// ----------------------------------------------------------------------------
// mot_mul
// Shift-add multiplier, one multiplier bit per cycle, stops when bits run out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mot_mul (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [mot_pkg::MA_W-1:0] a,
	input  logic [mot_pkg::MB_W-1:0] b,
	output logic                     done,
	output logic [mot_pkg::MP_W-1:0] p
);
	import mot_pkg::*;

	logic            busy_q;
	logic            done_q;
	logic [MP_W-1:0] a_q;
	logic [MB_W-1:0] b_q;
	logic [MP_W-1:0] acc_q;

	assign done = done_q;
	assign p    = acc_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && b_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// shift and add
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= MP_W'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	`ASSERT_CLK(a_done_from_busy, done_q |-> $past(busy_q), "product without run")
	`ASSERT_NEVER(a_no_restart, start && busy_q, "multiplier restarted while busy")
endmodule

// ----- rtl/core/mot_back.sv -----
// ----------------------------------------------------------------------------
// mot_back
// Histogram update, exact between-class variance search and histogram clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mot_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  mot_pkg::item_t head,
	output logic           pop,
	output mot_pkg::res_t  res
);
	import mot_pkg::*;

	bstate_t state_q, state_d;
	op_t     op_q;

	logic [N_W-1:0]   mem [BINS];
	logic [N_W-1:0]   rd_q;
	logic [BIN_W-1:0] raddr;
	logic             we;
	logic [BIN_W-1:0] waddr;
	logic [N_W-1:0]   wdata;

	logic             vld_s1;
	item_t            it_s1;
	logic             fwd_vld_q;
	logic [BIN_W-1:0] fwd_addr_q;
	logic [N_W-1:0]   fwd_data_q;
	logic [N_W-1:0]   cur_cnt;

	logic [N_W-1:0]   tot_q;
	logic [S_W-1:0]   sum_q;
	logic             ovf_q;
	logic [BIN_W-1:0] t_q;
	logic [N_W-1:0]   n1_q;
	logic [S_W-1:0]   s1_q;
	logic [N_W-1:0]   n2;
	logic [S_W-1:0]   s2;
	logic [P1_W-1:0]  pa_q;
	logic [P1_W-1:0]  d_q;
	logic [SQ_W-1:0]  dsq_q;
	logic [DEN_W-1:0] den_q;
	logic [CMP_W-1:0] lhs_q;
	logic [SQ_W-1:0]  bsq_q;
	logic [DEN_W-1:0] bden_q;
	logic [BIN_W-1:0] best_q;

	logic             mul_start;
	logic [MA_W-1:0]  mul_a;
	logic [MB_W-1:0]  mul_b;
	logic             mul_done;
	logic [MP_W-1:0]  mul_p;
	logic [P1_W-1:0]  pb;

	assign n2 = tot_q - n1_q;
	assign s2 = sum_q - s1_q;
	assign pb = mul_p[P1_W-1:0];

	mot_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_INIT:  if (t_q == BIN_W'(BINS - 1)) state_d = B_RUN;
			B_RUN:   if (vld_s1 && it_s1.last) state_d = B_RD;
			B_RD:    state_d = B_ACC;
			B_ACC:   state_d = B_CHK;
			B_CHK:   state_d = (n1_q == '0 || n1_q >= tot_q) ? B_NEXT : B_MGO;
			B_MGO:   state_d = B_MWAIT;
			B_MWAIT: if (mul_done) state_d = (op_q == OP_RHS) ? B_NEXT : B_MGO;
			B_NEXT:  state_d = (t_q == BIN_W'(BINS - 1)) ? B_CLR : B_RD;
			B_CLR:   if (t_q == BIN_W'(BINS - 1)) state_d = B_DONE;
			B_DONE:  state_d = B_RUN;
			default: state_d = B_RUN;
		endcase
	end

	// pick current bin count, bypassing the write of the previous cycle
	assign cur_cnt = (fwd_vld_q && fwd_addr_q == it_s1.pixel) ? fwd_data_q : rd_q;

	// outputs: memory ports, queue pop, multiplier operands
	always_comb begin
		pop       = 1'b0;
		raddr     = t_q;
		we        = 1'b0;
		waddr     = t_q;
		wdata     = '0;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			B_RUN: begin
				pop   = !empty && !(vld_s1 && it_s1.last);
				raddr = head.pixel;
				we    = vld_s1 && it_s1.inc;
				waddr = it_s1.pixel;
				wdata = cur_cnt + 1'b1;
			end
			B_INIT, B_CLR: we = 1'b1;
			B_MGO: begin
				mul_start = 1'b1;
				case (op_q)
					OP_PA:   begin mul_a = MA_W'(n2);     mul_b = MB_W'(s1_q); end
					OP_PB:   begin mul_a = MA_W'(n1_q);   mul_b = MB_W'(s2);   end
					OP_DSQ:  begin mul_a = MA_W'(d_q);    mul_b = MB_W'(d_q);  end
					OP_DEN:  begin mul_a = MA_W'(n1_q);   mul_b = MB_W'(n2);   end
					OP_LHS:  begin mul_a = MA_W'(dsq_q);  mul_b = MB_W'(bden_q); end
					OP_RHS:  begin mul_a = MA_W'(bsq_q);  mul_b = MB_W'(den_q); end
					default: begin mul_a = '0;            mul_b = '0;          end
				endcase
			end
			default: ;
		endcase
	end

	// histogram memory
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_INIT;
			vld_s1    <= 1'b0;
			fwd_vld_q <= 1'b0;
			op_q      <= OP_PA;
			t_q       <= '0;
			tot_q     <= '0;
			sum_q     <= '0;
			ovf_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			vld_s1    <= pop;
			fwd_vld_q <= we;
			case (state_q)
				B_RUN: begin
					t_q <= '0;
					if (vld_s1) begin
						if (it_s1.inc) begin
							tot_q <= tot_q + 1'b1;
							sum_q <= sum_q + S_W'(it_s1.pixel);
						end
						if (it_s1.ovf) ovf_q <= 1'b1;
					end
				end
				B_CHK: op_q <= OP_PA;
				B_MWAIT: begin
					if (mul_done) begin
						case (op_q)
							OP_PA:   op_q <= OP_PB;
							OP_PB:   op_q <= OP_DSQ;
							OP_DSQ:  op_q <= OP_DEN;
							OP_DEN:  op_q <= OP_LHS;
							OP_LHS:  op_q <= OP_RHS;
							default: op_q <= OP_PA;
						endcase
					end
				end
				B_NEXT: t_q <= t_q + 1'b1;
				B_INIT, B_CLR: t_q <= t_q + 1'b1;
				B_DONE: begin
					tot_q <= '0;
					sum_q <= '0;
					ovf_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop) it_s1 <= head;
		fwd_addr_q <= waddr;
		fwd_data_q <= wdata;
		case (state_q)
			B_RUN: begin
				n1_q   <= '0;
				s1_q   <= '0;
				bsq_q  <= '0;
				bden_q <= DEN_W'(1);
				best_q <= '0;
			end
			B_ACC: begin
				n1_q <= n1_q + rd_q;
				s1_q <= s1_q + S_W'(S_W'(t_q) * S_W'(rd_q));
			end
			B_MWAIT: begin
				if (mul_done) begin
					case (op_q)
						OP_PA:  pa_q <= mul_p[P1_W-1:0];
						OP_PB:  d_q  <= (pa_q >= pb) ? pa_q - pb : pb - pa_q;
						OP_DSQ: dsq_q <= mul_p[SQ_W-1:0];
						OP_DEN: den_q <= mul_p[DEN_W-1:0];
						OP_LHS: lhs_q <= mul_p[CMP_W-1:0];
						OP_RHS: begin
							if (lhs_q > mul_p[CMP_W-1:0]) begin
								bsq_q  <= dsq_q;
								bden_q <= den_q;
								best_q <= t_q;
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	// frame result
	always_comb begin
		res.done        = (state_q == B_DONE);
		res.threshold   = best_q;
		res.empty_frame = (tot_q == '0);
		res.overflow    = ovf_q;
	end
endmodule

// ----- rtl/core/masked_otsu_threshold_finder.sv -----
// ----------------------------------------------------------------------------
// masked_otsu_threshold_finder
// Per-frame Otsu threshold over masked 8-bit gray pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel: a word (pixel, in_mask, last) is taken at a rising edge
//   with start high and busy low; up to one pixel per cycle while streaming.
//   Config channel: cfg_data sets mask_enable when cfg_valid and cfg_ready
//   are high; write it only between frames.
//   Result channel: done is high for one cycle with threshold, empty_frame
//   and overflow; the receiver has no stall, so it must take it then.
// Frame sequence:
//   After the last pixel, busy stays high through the result cycle. The scan
//   runs bins 0..255; each scored bin takes six shift-add products in the
//   shared multiplier. A histogram clear over all 256 bins follows before
//   done rises. Pixels themselves stream at one per cycle while busy is
//   low.
// Reset:
//   arst_n clears control, counts and mask_enable, then a sweep over all 256
//   bins zeroes the histogram; pixels queue up meanwhile until busy rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module masked_otsu_threshold_finder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [mot_pkg::BIN_W-1:0] pixel,
	input  logic                      in_mask,
	input  logic                      last,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_data,
	output logic                      done,
	output logic [mot_pkg::BIN_W-1:0] threshold,
	output logic                      empty_frame,
	output logic                      overflow
);
	import mot_pkg::*;

	item_t q_wdata;
	item_t q_rdata;
	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_empty;
	res_t  res;

	mot_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.pixel      (pixel),
		.in_mask    (in_mask),
		.last       (last),
		.busy       (busy),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.frame_done (res.done),
		.push       (q_push),
		.word       (q_wdata),
		.full       (q_full)
	);

	mot_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	mot_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (q_empty),
		.head   (q_rdata),
		.pop    (q_pop),
		.res    (res)
	);

	assign done        = res.done;
	assign threshold   = res.threshold;
	assign empty_frame = res.empty_frame;
	assign overflow    = res.overflow;

	`ASSERT_CLK(a_done_while_busy, done |-> busy, "result without pending frame")
endmodule
